### hw/rtl/scfe_pkg.sv
// Shared types and constants for the servo command frame encoder.
// No dependencies; imported by the top level, front end, frame queue and byte sender.
package scfe_pkg;

    typedef enum logic [3:0] {
        OP_SET_TORQUE  = 4'd0,
        OP_GET_TORQUE  = 4'd1,
        OP_PD_QUICK    = 4'd2,
        OP_SET_PD      = 4'd3,
        OP_SET_I       = 4'd4,
        OP_GET_PD      = 4'd5,
        OP_GET_I       = 4'd6,
        OP_GET_ANGLE12 = 4'd7,
        OP_SET_ANGLE12 = 4'd8,
        OP_GET_ANGLE8  = 4'd9,
        OP_SET_ANGLE8  = 4'd10,
        OP_PASSIVE     = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        RPL_NONE   = 3'd0,
        RPL_TORQUE = 3'd1,
        RPL_PD     = 3'd2,
        RPL_I      = 3'd3,
        RPL_POS12  = 3'd4,
        RPL_POS8   = 3'd5
    } t_reply;

    // register indexes on the config port
    localparam logic REG_ANGLE_LO = 1'b0;
    localparam logic REG_ANGLE_HI = 1'b1;

    localparam logic [11:0] ANGLE_LO_RST = 12'd0;
    localparam logic [11:0] ANGLE_HI_RST = 12'd4095;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] LONG_ADDR = 8'hE0;
    localparam logic [7:0] PD_QUICK  = 8'h0B;

    localparam logic [7:0] CMD_SET_TORQUE  = 8'd186;
    localparam logic [7:0] CMD_GET_TORQUE  = 8'd187;
    localparam logic [7:0] CMD_SET_PD      = 8'd176;
    localparam logic [7:0] CMD_SET_I       = 8'd183;
    localparam logic [7:0] CMD_GET_PD      = 8'd175;
    localparam logic [7:0] CMD_GET_I       = 8'd182;
    localparam logic [7:0] CMD_GET_ANGLE12 = 8'd173;
    localparam logic [7:0] CMD_SET_ANGLE12 = 8'd200;

    localparam logic [2:0] SHORT_GET_ANGLE8 = 3'd5;
    localparam logic [2:0] SHORT_PASSIVE    = 3'd6;
    localparam logic [7:0] PASSIVE_DATA     = 8'd16;
    localparam logic [2:0] MODE_MAX         = 3'd4;

    // index of the checksum byte for each frame length
    localparam logic [2:0] LAST_LONG  = 3'd6;
    localparam logic [2:0] LAST_QUICK = 3'd5;
    localparam logic [2:0] LAST_SHORT = 3'd3;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [2:0]  drive_mode;
        logic [7:0]  value_b;
        logic [13:0] value_a;
        logic [4:0]  servo_id;
        logic [3:0]  operation;
    } t_cmd;

    // one fully built frame waiting to be sent
    typedef struct packed {
        logic [5:0][7:0] body;
        logic [6:0]      cks;
        logic [2:0]      last_idx;
        t_reply          reply;
    } t_frame;

endpackage

### hw/rtl/servo_command_frame_encoder_top.sv
// Top level of the servo command frame encoder: config registers, front end,
// frame queue and byte sender. Depends on scfe_pkg, scfe_front, scfe_fifo, scfe_back.
//
//  channel   | dir | payload
//  ----------+-----+------------------------------------------------------
//  s_axis    | in  | tdata: operation, servo_id, value_a, value_b, drive_mode
//  m_axis    | out | tdata: frame_byte; tlast: last_byte; tuser: reply_kind
//  apb       | in  | angle_lower_bound @0x0, angle_upper_bound @0x4
//
// A frame leaves one byte per cycle while m_axis_tready is high: long frames are 7
// bytes, quick PD 6, short 4; the byte sender sets the rate; frames run back to back.
// Commands enter through a two-frame queue and are taken whenever it has room;
// a rejected command is still taken and sends nothing.
// Reset is synchronous, active low; it clears the reply kind and sets the bounds
// back to 0 and 4095.
// m_axis stalls hold the current byte and fill the queue before s_axis stalls.
module servo_command_frame_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] operation, [8:4] servo_id, [22:9] value_a, [30:23] value_b,
    // [33:31] drive_mode, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // [2:0] reply_kind
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scfe_pkg::*;

    logic [11:0] r_angle_lo;
    logic [11:0] r_angle_hi;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_frame      frame_in;
    t_frame      frame_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_lo <= ANGLE_LO_RST;
            r_angle_hi <= ANGLE_HI_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ANGLE_LO: r_angle_lo <= pwdata[11:0];
                REG_ANGLE_HI: r_angle_hi <= pwdata[11:0];
                default:      r_angle_lo <= r_angle_lo;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ANGLE_LO: prdata = {20'd0, r_angle_lo};
            REG_ANGLE_HI: prdata = {20'd0, r_angle_hi};
            default:      prdata = '0;
        endcase
    end

    scfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (t_cmd'(s_axis_tdata[33:0])),
        .i_angle_lo (r_angle_lo),
        .i_angle_hi (r_angle_hi),
        .i_full     (full),
        .o_push     (push),
        .o_frame    (frame_in)
    );

    scfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (frame_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (frame_out)
    );

    scfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_frame (frame_out),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_reply (m_axis_tuser)
    );

endmodule

### hw/rtl/scfe_front.sv
// Front end: accepts commands, checks them and builds the frame bytes and checksum.
// Depends on scfe_pkg; tracks the expected reply kind.
module scfe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  scfe_pkg::t_cmd i_cmd,
    input  logic [11:0]    i_angle_lo,
    input  logic [11:0]    i_angle_hi,
    input  logic           i_full,
    output logic           o_push,
    output scfe_pkg::t_frame o_frame
);
    import scfe_pkg::*;

    t_reply          r_reply;
    t_reply          n_reply;
    logic [5:0][7:0] body;
    logic [2:0]      last_idx;
    logic            keep;
    logic [2:0]      mode_sat;
    logic [7:0]      sum;
    logic            accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        mode_sat = (i_cmd.drive_mode > MODE_MAX) ? MODE_MAX : i_cmd.drive_mode;
        body     = '0;
        body[0]  = HDR_BYTE;
        body[1]  = LONG_ADDR;
        body[3]  = {3'b000, i_cmd.servo_id};
        last_idx = LAST_LONG;
        keep     = 1'b1;
        n_reply  = r_reply;
        case (t_op'(i_cmd.operation))
            OP_SET_TORQUE: begin
                body[2] = CMD_SET_TORQUE;
                body[4] = {1'b0, i_cmd.value_a[13:7]};
                body[5] = {1'b0, i_cmd.value_a[6:0]};
                n_reply = RPL_TORQUE;
            end
            OP_GET_TORQUE: begin
                body[2] = CMD_GET_TORQUE;
                n_reply = RPL_TORQUE;
            end
            OP_PD_QUICK: begin
                body[1]  = LONG_ADDR | {3'b000, i_cmd.servo_id};
                body[2]  = PD_QUICK;
                body[3]  = i_cmd.value_a[7:0];
                body[4]  = i_cmd.value_b;
                last_idx = LAST_QUICK;
                n_reply  = RPL_PD;
            end
            OP_SET_PD: begin
                body[2] = CMD_SET_PD;
                body[4] = i_cmd.value_a[7:0];
                body[5] = i_cmd.value_b;
                n_reply = RPL_PD;
            end
            OP_SET_I: begin
                body[2] = CMD_SET_I;
                body[4] = i_cmd.value_a[7:0];
                body[5] = i_cmd.value_a[7:0];
                n_reply = RPL_I;
            end
            OP_GET_PD: begin
                body[2] = CMD_GET_PD;
                n_reply = RPL_PD;
            end
            OP_GET_I: begin
                body[2] = CMD_GET_I;
                n_reply = RPL_I;
            end
            OP_GET_ANGLE12: begin
                body[2] = CMD_GET_ANGLE12;
                n_reply = RPL_POS12;
            end
            OP_SET_ANGLE12: begin
                body[2] = CMD_SET_ANGLE12;
                body[4] = {3'b000, i_cmd.value_a[11:7]};
                body[5] = {1'b0, i_cmd.value_a[6:0]};
                keep    = (i_cmd.value_a >= {2'b00, i_angle_lo})
                       && (i_cmd.value_a <= {2'b00, i_angle_hi});
            end
            OP_GET_ANGLE8: begin
                body[1]  = {SHORT_GET_ANGLE8, i_cmd.servo_id};
                body[3]  = '0;
                last_idx = LAST_SHORT;
                n_reply  = RPL_POS8;
            end
            OP_SET_ANGLE8: begin
                body[1]  = {mode_sat, i_cmd.servo_id};
                body[2]  = i_cmd.value_a[7:0];
                body[3]  = '0;
                last_idx = LAST_SHORT;
            end
            OP_PASSIVE: begin
                body[1]  = {SHORT_PASSIVE, i_cmd.servo_id};
                body[2]  = PASSIVE_DATA;
                body[3]  = '0;
                last_idx = LAST_SHORT;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        // unused body bytes are zero, so one XOR covers every frame length
        sum = body[1] ^ body[2] ^ body[3] ^ body[4] ^ body[5];
    end

    assign o_push           = accept && keep;
    assign o_frame.body     = body;
    assign o_frame.cks      = sum[6:0];
    assign o_frame.last_idx = last_idx;
    assign o_frame.reply    = n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply <= RPL_NONE;
        end else if (o_push) begin
            r_reply <= n_reply;
        end
    end

endmodule

### hw/rtl/scfe_fifo.sv
// Short frame queue between the front end and the byte sender.
// Depends on scfe_pkg for the frame type and depth.
module scfe_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  scfe_pkg::t_frame i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output scfe_pkg::t_frame o_data
);
    import scfe_pkg::*;

    t_frame               r_mem [QDEPTH];
    logic [QAW-1:0]       r_wr;
    logic [QAW-1:0]       r_rd;
    logic [QAW:0]         r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hw/rtl/scfe_back.sv
// Byte sender: takes frames from the queue and sends one byte per cycle
// while i_ready is high. Depends on scfe_pkg for the frame type.
module scfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  scfe_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic [2:0]       o_reply
);
    import scfe_pkg::*;

    logic       r_busy;
    t_frame     r_frame;
    logic [2:0] r_idx;
    logic       done;

    assign o_valid = r_busy;
    assign o_last  = (r_idx == r_frame.last_idx);
    assign o_byte  = o_last ? {1'b0, r_frame.cks} : r_frame.body[r_idx];
    assign o_reply = r_frame.reply;

    // next frame loads on the cycle its predecessor's checksum goes out
    assign done  = r_busy && i_ready && o_last;
    assign o_pop = !i_empty && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

### hw/rtl/scfe_checker.sv
// Port-level checks for the servo command frame encoder, bound to the top level.
// Depends only on the top-level ports.
module scfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);

    // stalled output byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output request changed while stalled");

    // checksum is masked to 7 bits
    a_cks_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[7])
        else $error("checksum byte has bit 7 set");

    // a byte sent right after a frame's last byte opens a new frame
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && m_axis_tready && m_axis_tlast)
            && m_axis_tvalid |-> m_axis_tdata == 8'hFF && !m_axis_tlast)
        else $error("frame does not start with header");

    a_reply_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= 3'd5)
        else $error("reply kind out of range");

endmodule

bind servo_command_frame_encoder_top scfe_checker u_scfe_checker (.*);

### test/tb_servo_command_frame_encoder_top.sv
// Self-checking testbench for servo_command_frame_encoder_top: drives commands on the
// stream input and the angle bounds over APB, and predicts every frame byte.
// Depends on scfe_pkg (command and reply types) and the RTL top level.
module tb_servo_command_frame_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scfe_pkg::*;

    // frame constants, kept independent of the RTL package
    localparam logic [7:0] FRAME_HDR        = 8'hFF;
    localparam logic [7:0] ADDR_LONG        = 8'hE0;
    localparam logic [7:0] QUICK_PD_CMD     = 8'h0B;
    localparam logic [6:0] CKS_MASK         = 7'h7F;
    localparam logic [7:0] CODE_SET_TORQUE  = 8'd186;
    localparam logic [7:0] CODE_GET_TORQUE  = 8'd187;
    localparam logic [7:0] CODE_SET_PD      = 8'd176;
    localparam logic [7:0] CODE_SET_I       = 8'd183;
    localparam logic [7:0] CODE_GET_PD      = 8'd175;
    localparam logic [7:0] CODE_GET_I       = 8'd182;
    localparam logic [7:0] CODE_GET_ANGLE12 = 8'd173;
    localparam logic [7:0] CODE_SET_ANGLE12 = 8'd200;
    localparam logic [2:0] KIND_GET_ANGLE8  = 3'd5;
    localparam logic [2:0] KIND_PASSIVE     = 3'd6;
    localparam logic [7:0] PASSIVE_PAYLOAD  = 8'd16;
    localparam logic [2:0] MODE_LIMIT       = 3'd4;
    localparam logic [3:0] OP_CODE_MAX      = 4'd15;

    localparam int REG_LOWER = 0;
    localparam int REG_UPPER = 1;

    localparam int DIR_LO         = 100;
    localparam int DIR_HI         = 3000;
    localparam int PHASES         = 7;
    localparam int CMDS_PER_PHASE = 48;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_REPORTS    = 10;

    typedef logic [5:0][7:0] t_bytes;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] reply;
    } t_out_byte;

    typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_style;

    class frame_scoreboard;
        logic [11:0] lo_bound = 12'd0;
        logic [11:0] hi_bound = 12'd4095;
        t_reply      reply_kind = RPL_NONE;
        t_out_byte   pending_bytes[$];
        int errors, commands, dropped, bytes_checked;

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        function void set_bound(int idx, logic [11:0] val);
            if (idx == REG_LOWER) lo_bound = val;
            else if (idx == REG_UPPER) hi_bound = val;
        endfunction

        function t_bytes long_body(logic [7:0] code, logic [4:0] id, logic [7:0] v4,
                                   logic [7:0] v5);
            t_bytes b;
            b[0] = FRAME_HDR;
            b[1] = ADDR_LONG;
            b[2] = code;
            b[3] = {3'b000, id};
            b[4] = v4;
            b[5] = v5;
            return b;
        endfunction

        function t_bytes short_body(logic [7:0] addr, logic [7:0] data);
            t_bytes b;
            b    = '0;
            b[0] = FRAME_HDR;
            b[1] = addr;
            b[2] = data;
            return b;
        endfunction

        function void push_frame(t_bytes body, int len);
            logic [7:0] cks;
            cks = 8'h00;
            for (int i = 1; i < len; i++) cks ^= body[i];
            for (int i = 0; i < len; i++) pending_bytes.push_back({body[i], 1'b0, reply_kind});
            pending_bytes.push_back({1'b0, cks[6:0] & CKS_MASK, 1'b1, reply_kind});
        endfunction

        // work out the frame for one accepted command
        function void note_command(t_cmd c);
            t_bytes     body;
            int         len;
            logic [2:0] mode;
            commands++;
            len  = 0;
            body = '0;
            case (c.operation)
                OP_SET_TORQUE: begin
                    reply_kind = RPL_TORQUE;
                    body = long_body(CODE_SET_TORQUE, c.servo_id, {1'b0, c.value_a[13:7]},
                                     {1'b0, c.value_a[6:0]});
                    len = 6;
                end
                OP_GET_TORQUE: begin
                    reply_kind = RPL_TORQUE;
                    body = long_body(CODE_GET_TORQUE, c.servo_id, 8'h00, 8'h00);
                    len = 6;
                end
                OP_PD_QUICK: begin
                    reply_kind = RPL_PD;
                    body[0] = FRAME_HDR;
                    body[1] = ADDR_LONG | {3'b000, c.servo_id};
                    body[2] = QUICK_PD_CMD;
                    body[3] = c.value_a[7:0];
                    body[4] = c.value_b;
                    len = 5;
                end
                OP_SET_PD: begin
                    reply_kind = RPL_PD;
                    body = long_body(CODE_SET_PD, c.servo_id, c.value_a[7:0], c.value_b);
                    len = 6;
                end
                OP_SET_I: begin
                    reply_kind = RPL_I;
                    body = long_body(CODE_SET_I, c.servo_id, c.value_a[7:0], c.value_a[7:0]);
                    len = 6;
                end
                OP_GET_PD: begin
                    reply_kind = RPL_PD;
                    body = long_body(CODE_GET_PD, c.servo_id, 8'h00, 8'h00);
                    len = 6;
                end
                OP_GET_I: begin
                    reply_kind = RPL_I;
                    body = long_body(CODE_GET_I, c.servo_id, 8'h00, 8'h00);
                    len = 6;
                end
                OP_GET_ANGLE12: begin
                    reply_kind = RPL_POS12;
                    body = long_body(CODE_GET_ANGLE12, c.servo_id, 8'h00, 8'h00);
                    len = 6;
                end
                OP_SET_ANGLE12: begin
                    // bounds are 12 bits, so anything from 4096 up falls out
                    if (c.value_a >= lo_bound && c.value_a <= hi_bound) begin
                        body = long_body(CODE_SET_ANGLE12, c.servo_id,
                                         {3'b000, c.value_a[11:7]}, {1'b0, c.value_a[6:0]});
                        len = 6;
                    end
                end
                OP_GET_ANGLE8: begin
                    reply_kind = RPL_POS8;
                    body = short_body({KIND_GET_ANGLE8, c.servo_id}, 8'h00);
                    len = 3;
                end
                OP_SET_ANGLE8: begin
                    mode = (c.drive_mode > MODE_LIMIT) ? MODE_LIMIT : c.drive_mode;
                    body = short_body({mode, c.servo_id}, c.value_a[7:0]);
                    len = 3;
                end
                OP_PASSIVE: begin
                    body = short_body({KIND_PASSIVE, c.servo_id}, PASSIVE_PAYLOAD);
                    len = 3;
                end
                default: ;
            endcase
            if (len == 0) dropped++;
            else push_frame(body, len);
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic [2:0] reply);
            t_out_byte want;
            if (pending_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last=%0b reply=%0d", data, last, reply));
                return;
            end
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (want.data !== data || want.last !== last || want.reply !== reply)
                report($sformatf("byte %0d: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                                 bytes_checked, want.data, want.last, want.reply,
                                 data, last, reply));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();
    t_rx_style       rx_style = RX_FLOW;
    int              rx_cycle = 0;
    int              bound_writes = 0;

    servo_command_frame_encoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one block for both sides, so a request is noted before a same-edge byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_command(t_cmd'(s_axis_tdata[33:0]));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // receiver backpressure in one of four randomly chosen styles
    always @(negedge i_clk) begin
        if (rx_cycle % 150 == 0) rx_style = t_rx_style'($urandom_range(0, 3));
        case (rx_style)
            RX_FLOW:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_axis_tready <= (rx_cycle % 5 != 0);
            default:     m_axis_tready <= 1'b1;
        endcase
        rx_cycle++;
    end

    function automatic t_cmd make_command(t_op op, int id, int va, int vb, int mode);
        t_cmd c;
        c.operation  = op;
        c.servo_id   = 5'(id);
        c.value_a    = 14'(va);
        c.value_b    = 8'(vb);
        c.drive_mode = 3'(mode);
        return c;
    endfunction

    function automatic t_cmd random_command();
        t_cmd c;
        int   lo;
        int   hi;
        if ($urandom_range(0, 19) == 0)
            c.operation = 4'($urandom_range(int'(OP_PASSIVE) + 1, OP_CODE_MAX));
        else
            c.operation = 4'($urandom_range(0, int'(OP_PASSIVE)));
        c.servo_id   = 5'($urandom);
        c.value_a    = 14'($urandom);
        c.value_b    = 8'($urandom);
        c.drive_mode = 3'($urandom);
        if (c.operation == OP_SET_ANGLE12) begin
            lo = sb.lo_bound;
            hi = sb.hi_bound;
            case ($urandom_range(0, 5))
                0, 1: if (lo <= hi) c.value_a = 14'($urandom_range(lo, hi));
                2: c.value_a = 14'(lo);
                3: c.value_a = 14'(hi);
                4: c.value_a = 14'(lo - 1);
                5: c.value_a = 14'(hi + 1);
                default: ;
            endcase
        end
        return c;
    endfunction

    // all driver tasks start and end just after a falling edge
    task automatic send_command(input t_cmd c);
        s_axis_tdata  <= {6'b000000, c};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 40'({$urandom, $urandom});
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write a bound, then read it back
    task automatic write_bound(input int idx, input logic [11:0] val);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= {20'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        sb.set_bound(idx, val);
        bound_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {20'h00000, val})
            sb.report($sformatf("bound %0d readback: expected %03h, got %08h", idx, val, got));
    endtask

    task automatic run_directed();
        send_command(make_command(OP_SET_TORQUE, 31, 16383, 255, 7));
        send_command(make_command(OP_SET_TORQUE, 0, 0, 0, 0));
        send_command(make_command(OP_GET_TORQUE, 17, 16383, 255, 7));
        send_command(make_command(OP_PD_QUICK, 31, 16383, 255, 0));
        send_command(make_command(OP_SET_PD, 5, 16128, 0, 0));
        send_command(make_command(OP_SET_I, 9, 677, 0, 0));
        send_command(make_command(OP_GET_PD, 31, 0, 0, 0));
        send_command(make_command(OP_GET_I, 1, 5000, 12, 3));
        send_command(make_command(OP_GET_ANGLE12, 0, 0, 0, 0));
        // angle just outside and at each bound, plus wide values
        send_command(make_command(OP_SET_ANGLE12, 3, DIR_LO - 1, 0, 0));
        send_command(make_command(OP_SET_ANGLE12, 3, DIR_LO, 0, 0));
        send_command(make_command(OP_SET_ANGLE12, 30, DIR_HI, 0, 0));
        send_command(make_command(OP_SET_ANGLE12, 30, DIR_HI + 1, 0, 0));
        send_command(make_command(OP_SET_ANGLE12, 7, 4096, 0, 0));
        send_command(make_command(OP_SET_ANGLE12, 7, 16383, 0, 0));
        send_command(make_command(OP_GET_ANGLE8, 31, 16383, 255, 7));
        send_command(make_command(OP_SET_ANGLE8, 31, 16383, 0, 7));
        send_command(make_command(OP_SET_ANGLE8, 12, 128, 0, 4));
        send_command(make_command(OP_SET_ANGLE8, 0, 0, 0, 0));
        send_command(make_command(OP_SET_ANGLE8, 21, 85, 0, 5));
        send_command(make_command(OP_PASSIVE, 31, 16383, 255, 7));
        for (int op = int'(OP_PASSIVE) + 1; op <= OP_CODE_MAX; op++)
            send_command(t_cmd'({3'd7, 8'hFF, 14'h3FFF, 5'd31, 4'(op)}));
    endtask

    task automatic run_random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_command(random_command());
                sent++;
            end
            case ($urandom_range(0, 9))
                0:       drain_frames();
                1, 2, 3: ;
                default: idle_sender($urandom_range(1, 6));
            endcase
        end
    endtask

    initial begin
        int lo_val;
        int hi_val;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_bound(REG_LOWER, 12'(DIR_LO));
        write_bound(REG_UPPER, 12'(DIR_HI));
        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_frames();
            case (ph)
                0: begin lo_val = 0;    hi_val = 4095; end
                1: begin lo_val = 1000; hi_val = 3000; end
                2: begin lo_val = 2048; hi_val = 2048; end
                3: begin lo_val = 3000; hi_val = 100;  end  // inverted: nothing passes
                4: begin lo_val = 0;    hi_val = 0;    end
                5: begin lo_val = 4095; hi_val = 4095; end
                default: begin
                    lo_val = $urandom_range(0, 2047);
                    hi_val = $urandom_range(lo_val, 4095);
                end
            endcase
            write_bound(REG_LOWER, 12'(lo_val));
            write_bound(REG_UPPER, 12'(hi_val));
            run_random_phase(CMDS_PER_PHASE);
        end

        drain_frames();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d bytes never arrived", sb.pending()));
        $display("Sent %0d commands (%0d produced no frame), checked %0d frame bytes",
                 sb.commands, sb.dropped, sb.bytes_checked);
        $display("across %0d bound writes; %0d errors", bound_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("servo_command_frame_encoder_top regression: pass");
        end else begin
            $display("servo_command_frame_encoder_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d bytes outstanding", sb.pending());
        $display("servo_command_frame_encoder_top regression: fail");
        $finish;
    end

endmodule
